// ===== rtl/core/tbwb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths and codes for the track buffer write-back cache.
// Used by tbwb_plan and track_buffer_write_back_cache; depends on nothing.
package tbwb_pkg;

   // Geometry of the buffered track and the disk behind it.
   localparam int TRACK_BITS        = 10;
   localparam int SECTORS_PER_TRACK = 32;
   localparam int SECTOR_BYTES      = 128;
   localparam int BLOCKS_PER_TRACK  = 16;

   // Widths of the request and result fields.
   localparam int CMD_W    = 3;
   localparam int DISK_W   = 2;
   localparam int TRACK_W  = 10;
   localparam int SECTOR_W = 6;
   localparam int KIND_W   = 2;
   localparam int DRIVE_W  = 4;
   localparam int BLOCK_W  = 14;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;

   // Results one request can cause, and the width of a count of them.
   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int INDEX_W     = $clog2(MAX_RESULTS);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE_SYNC = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE_BACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FILL       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE       = 2'd2;

   // Completion and transfer status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   // The hard disk is addressed under a different physical drive number.
   localparam logic [DISK_W-1:0]  HARD_DISK  = 2'd3;
   localparam logic [DRIVE_W-1:0] HARD_DRIVE = 4'd10;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [DISK_W-1:0]   disk;
      logic [TRACK_W-1:0]  track;
      logic [SECTOR_W-1:0] sector;
      logic                disk_fault;
   } request_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [DRIVE_W-1:0]  drive;
      logic [BLOCK_W-1:0]  first_block;
      logic [OFFSET_W-1:0] buffer_offset;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

   // Tag, dirty flag and sticky error of the single track buffer.
   typedef struct packed {
      logic                  valid;
      logic                  dirty;
      logic [TRACK_BITS-1:0] track;
      logic [DISK_W-1:0]     disk;
      logic                  last_error;
   } cache_state_type;

   // Everything one request decides: its results in order and the new state.
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] results;
      logic [COUNT_W-1:0]           count;
      cache_state_type              next_state;
   } plan_type;

endpackage

// ===== rtl/core/tbwb_plan.sv =====
`timescale 1ns / 1ps
// Decision logic for one request: lists the transfers and completion it causes
// and the buffer state it leaves. Depends on tbwb_pkg.
module tbwb_plan (
   input  tbwb_pkg::request_type     request,
   input  tbwb_pkg::cache_state_type state,
   output tbwb_pkg::plan_type        plan
);

   // Drive number of a disk: the hard disk moves to its own drive.
   function automatic logic [tbwb_pkg::DRIVE_W-1:0] drive_of(
      input logic [tbwb_pkg::DISK_W-1:0] disk
   );
      if (disk == tbwb_pkg::HARD_DISK) begin
         return tbwb_pkg::HARD_DRIVE;
      end
      return tbwb_pkg::DRIVE_W'(disk);
   endfunction

   // One transfer word for a disk and track.
   function automatic tbwb_pkg::result_type transfer_of(
      input logic [tbwb_pkg::KIND_W-1:0]     kind,
      input logic [tbwb_pkg::DISK_W-1:0]     disk,
      input logic [tbwb_pkg::TRACK_BITS-1:0] track,
      input logic                            fault
   );
      tbwb_pkg::result_type r;
      r.kind          = kind;
      r.drive         = drive_of(disk);
      r.first_block   = tbwb_pkg::BLOCK_W'(32'(track) * tbwb_pkg::BLOCKS_PER_TRACK);
      r.buffer_offset = '0;
      r.status        = fault ? tbwb_pkg::STATUS_FAILED : tbwb_pkg::STATUS_OK;
      r.last          = 1'b0;
      return r;
   endfunction

   logic [tbwb_pkg::TRACK_BITS-1:0] req_track;
   logic                            sector_ok;
   logic                            miss;
   logic [tbwb_pkg::SECTOR_W-1:0]   sector_index;
   logic [tbwb_pkg::OFFSET_W-1:0]   offset;

   assign req_track    = request.track[tbwb_pkg::TRACK_BITS-1:0];
   assign sector_ok    = (request.sector != '0) &&
                         (32'(request.sector) <= tbwb_pkg::SECTORS_PER_TRACK);
   assign miss         = !state.valid || (state.track != req_track) ||
                         (state.disk != request.disk);
   assign sector_index = request.sector - tbwb_pkg::SECTOR_W'(1);
   assign offset       = tbwb_pkg::OFFSET_W'(32'(sector_index) * tbwb_pkg::SECTOR_BYTES);

   // Results are appended in order: write-back, fill, write-through, completion.
   always_comb begin
      tbwb_pkg::cache_state_type s;
      tbwb_pkg::result_type      done;
      logic [tbwb_pkg::COUNT_W-1:0] n;

      s    = state;
      n    = '0;
      plan.results = '0;
      done = '0;
      done.kind = tbwb_pkg::KIND_DONE;
      done.last = 1'b1;

      case (request.command)
         tbwb_pkg::CMD_READ, tbwb_pkg::CMD_WRITE, tbwb_pkg::CMD_WRITE_SYNC: begin
            if (!sector_ok) begin
               done.status = tbwb_pkg::STATUS_RANGE;
            end else begin
               if (miss) begin
                  // Dirty buffer goes back before the new track is read in.
                  if (s.valid && s.dirty) begin
                     plan.results[n[tbwb_pkg::INDEX_W-1:0]] = transfer_of(
                        tbwb_pkg::KIND_WRITE_BACK, s.disk, s.track, request.disk_fault);
                     n = n + 1'b1;
                  end
                  plan.results[n[tbwb_pkg::INDEX_W-1:0]] = transfer_of(
                     tbwb_pkg::KIND_FILL, request.disk, req_track, request.disk_fault);
                  n = n + 1'b1;
                  s.last_error = request.disk_fault;
                  s.valid      = 1'b1;
                  s.dirty      = 1'b0;
                  s.track      = req_track;
                  s.disk       = request.disk;
               end
               // A read keeps the dirty flag; any write sets it.
               if (request.command != tbwb_pkg::CMD_READ) begin
                  s.dirty = 1'b1;
               end
               // Write-through: the buffer is valid and now dirty.
               if (request.command == tbwb_pkg::CMD_WRITE_SYNC) begin
                  plan.results[n[tbwb_pkg::INDEX_W-1:0]] = transfer_of(
                     tbwb_pkg::KIND_WRITE_BACK, s.disk, s.track, request.disk_fault);
                  n = n + 1'b1;
                  s.last_error = request.disk_fault;
                  s.dirty      = 1'b0;
               end
               done.buffer_offset = offset;
               done.status = s.last_error ? tbwb_pkg::STATUS_FAILED : tbwb_pkg::STATUS_OK;
            end
         end
         tbwb_pkg::CMD_FLUSH: begin
            if (s.valid && s.dirty) begin
               plan.results[n[tbwb_pkg::INDEX_W-1:0]] = transfer_of(
                  tbwb_pkg::KIND_WRITE_BACK, s.disk, s.track, request.disk_fault);
               n = n + 1'b1;
               s.last_error = request.disk_fault;
            end
            s.dirty = 1'b0;
            done.status = s.last_error ? tbwb_pkg::STATUS_FAILED : tbwb_pkg::STATUS_OK;
         end
         tbwb_pkg::CMD_INVALIDATE: begin
            s.valid = 1'b0;
            s.dirty = 1'b0;
            done.status = s.last_error ? tbwb_pkg::STATUS_FAILED : tbwb_pkg::STATUS_OK;
         end
         default: begin
            // Undefined commands only answer with a clean completion.
            done.status = tbwb_pkg::STATUS_OK;
         end
      endcase

      plan.results[n[tbwb_pkg::INDEX_W-1:0]] = done;
      plan.count      = n + 1'b1;
      plan.next_state = s;
   end

endmodule

// ===== rtl/core/track_buffer_write_back_cache.sv =====
`timescale 1ns / 1ps
// Top level of the single-track write-back buffer controller.
// Depends on tbwb_pkg and tbwb_plan.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_tvalid/tready    command, disk, track, sector, fault
//   rsp      out        rsp_tvalid/tready    transfer or completion word
//
// A request is decided in the cycle it is accepted; its one to four result
// words are held in a small result register file and sent one per cycle
// while the result port is ready; a request holds the single result port
// until its final word is taken. The next request is taken in the cycle the
// final word of the previous one is taken. Reset is synchronous and empties
// the buffer. A stalled result port holds the current word and blocks new requests.
module track_buffer_write_back_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0], disk[4:3], track[14:5], sector[20:15], disk_fault[21], zeros
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive[3:0], first_block[17:4], buffer_offset[29:18], status[31:30]
   output logic [31:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   tbwb_pkg::request_type     request;
   tbwb_pkg::plan_type        plan;
   tbwb_pkg::cache_state_type state_ff, state_in;
   tbwb_pkg::result_type [tbwb_pkg::MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [tbwb_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [tbwb_pkg::INDEX_W-1:0] index_ff, index_in;
   logic                         busy_ff, busy_in;
   tbwb_pkg::result_type         current;
   logic                         req_take;
   logic                         rsp_take;
   logic                         final_word;

   // Unpack the request word.
   assign request.command    = req_tdata[2:0];
   assign request.disk       = req_tdata[4:3];
   assign request.track      = req_tdata[14:5];
   assign request.sector     = req_tdata[20:15];
   assign request.disk_fault = req_tdata[21];

   tbwb_plan u_plan (
      .request (request),
      .state   (state_ff),
      .plan    (plan)
   );

   // Handshakes.
   assign current    = slot_ff[index_ff];
   assign final_word = (tbwb_pkg::COUNT_W'(index_ff) + 1'b1) == count_ff;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_tready = !busy_ff || (rsp_take && final_word);
   assign req_take   = req_tvalid && req_tready;

   // Result word out.
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {current.status, current.buffer_offset, current.first_block,
                        current.drive};
   assign rsp_tuser  = current.kind;
   assign rsp_tlast  = current.last;

   // Next-state logic for the result sequencer and buffer state.
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      index_in = index_ff;
      busy_in  = busy_ff;
      if (req_take) begin
         state_in = plan.next_state;
         slot_in  = plan.results;
         count_in = plan.count;
         index_in = '0;
         busy_in  = 1'b1;
      end else if (rsp_take) begin
         if (final_word) begin
            busy_in = 1'b0;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   // Control and buffer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= '0;
         index_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         index_ff <= index_in;
         busy_ff  <= busy_in;
      end
   end

   // Result words carry no reset.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // A dirty buffer always holds a valid track.
   a_dirty_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff.dirty |-> state_ff.valid)
      else $error("buffer dirty without valid tag");

   // The final word of a request is the completion and nothing else is.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == tbwb_pkg::KIND_DONE)))
      else $error("completion and last flag disagree");

   // The sequencer never runs past the words it holds.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (tbwb_pkg::COUNT_W'(index_ff) < count_ff))
      else $error("result index beyond result count");

   // An accepted request shows its first word in the next cycle.
   a_req_then_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_tvalid)
      else $error("accepted request produced no result");

endmodule

// ===== tb/sv/tb_track_buffer_write_back_cache.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the track buffer write-back cache.
// Depends on tbwb_pkg and the track_buffer_write_back_cache top level.
import tbwb_pkg::*;

// Tracks the buffer tag, dirty flag and sticky error, and keeps the transfer and
// completion words that each accepted request should produce, oldest first.
class cache_word_checker;
   result_type due_words[$];
   bit held_valid;
   bit held_dirty;
   logic [TRACK_BITS-1:0] held_track;
   logic [DISK_W-1:0] held_disk;
   bit sticky_error;
   int errors;
   int requests;
   int words_checked;
   int fills;
   int write_backs;
   int range_errors;

   function new();
      held_valid = 1'b0;
      held_dirty = 1'b0;
      held_track = '0;
      held_disk = '0;
      sticky_error = 1'b0;
      errors = 0;
      requests = 0;
      words_checked = 0;
      fills = 0;
      write_backs = 0;
      range_errors = 0;
   endfunction

   function void push_word(logic [KIND_W-1:0] kind, logic [DRIVE_W-1:0] drive,
                           logic [BLOCK_W-1:0] block, logic [OFFSET_W-1:0] offset,
                           logic [STATUS_W-1:0] status, logic last);
      result_type word;
      word.kind = kind;
      word.drive = drive;
      word.first_block = block;
      word.buffer_offset = offset;
      word.status = status;
      word.last = last;
      due_words.push_back(word);
   endfunction

   // A disk transfer sets the sticky error to its own outcome.
   function void issue_transfer(logic [KIND_W-1:0] kind, logic [DISK_W-1:0] disk,
                                logic [TRACK_BITS-1:0] track, logic fault);
      logic [DRIVE_W-1:0] drive;
      logic [BLOCK_W-1:0] block;
      drive = (disk == HARD_DISK) ? HARD_DRIVE : DRIVE_W'(disk);
      block = BLOCK_W'(int'(track) * BLOCKS_PER_TRACK);
      sticky_error = fault;
      if (kind == KIND_FILL) begin
         fills++;
      end else begin
         write_backs++;
      end
      push_word(kind, drive, block, '0, fault ? STATUS_FAILED : STATUS_OK, 1'b0);
   endfunction

   // Only a valid, dirty buffer goes back to disk; the dirty flag clears either way.
   function void write_back_dirty(logic fault);
      if (held_valid && held_dirty) begin
         issue_transfer(KIND_WRITE_BACK, held_disk, held_track, fault);
      end
      held_dirty = 1'b0;
   endfunction

   function logic [STATUS_W-1:0] sticky_status();
      return sticky_error ? STATUS_FAILED : STATUS_OK;
   endfunction

   // Works out every word an accepted request causes and advances the buffer state.
   function void note_request(request_type req);
      logic [OFFSET_W-1:0] offset;
      bit tag_hit;
      requests++;
      if (req.command == CMD_READ || req.command == CMD_WRITE ||
          req.command == CMD_WRITE_SYNC) begin
         if (req.sector == 0 || req.sector > SECTORS_PER_TRACK) begin
            range_errors++;
            push_word(KIND_DONE, '0, '0, '0, STATUS_RANGE, 1'b1);
            return;
         end
         tag_hit = held_valid && held_track == req.track[TRACK_BITS-1:0] &&
                   held_disk == req.disk;
         if (!tag_hit) begin
            write_back_dirty(req.disk_fault);
            issue_transfer(KIND_FILL, req.disk, req.track[TRACK_BITS-1:0], req.disk_fault);
            held_valid = 1'b1;
            held_dirty = 1'b0;
            held_track = req.track[TRACK_BITS-1:0];
            held_disk = req.disk;
         end
         offset = OFFSET_W'(SECTOR_BYTES * (int'(req.sector) - 1));
         if (req.command != CMD_READ) begin
            held_dirty = 1'b1;
         end
         if (req.command == CMD_WRITE_SYNC) begin
            write_back_dirty(req.disk_fault);
         end
         push_word(KIND_DONE, '0, '0, offset, sticky_status(), 1'b1);
      end else if (req.command == CMD_FLUSH) begin
         write_back_dirty(req.disk_fault);
         push_word(KIND_DONE, '0, '0, '0, sticky_status(), 1'b1);
      end else if (req.command == CMD_INVALIDATE) begin
         held_valid = 1'b0;
         held_dirty = 1'b0;
         push_word(KIND_DONE, '0, '0, '0, sticky_status(), 1'b1);
      end else begin
         // Undefined commands leave the buffer alone and always report success.
         push_word(KIND_DONE, '0, '0, '0, STATUS_OK, 1'b1);
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         errors++;
         $display("%0t ERROR: result field %s expected %0d, actual %0d",
                  $time, name, want, seen);
      end
   endfunction

   // Compares an accepted result word with the oldest one still due.
   function void check_word(result_type got);
      result_type want;
      if (due_words.size() == 0) begin
         errors++;
         $display("%0t ERROR: unexpected result word, expected none, actual %p",
                  $time, got);
         return;
      end
      want = due_words.pop_front();
      words_checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("drive", want.drive, got.drive);
      compare_field("first_block", want.first_block, got.first_block);
      compare_field("buffer_offset", want.buffer_offset, got.buffer_offset);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
   endfunction
endclass

module tb_track_buffer_write_back_cache;

   localparam int CLOCK_HALF = 5;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_REQUESTS = 400;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAG_POOL = 4;
   localparam logic [CMD_W-1:0] CMD_FIRST_UNDEFINED = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   cache_word_checker board = new();
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;
   logic [DISK_W-1:0] pool_disk[TAG_POOL];
   logic [TRACK_W-1:0] pool_track[TAG_POOL];

   track_buffer_write_back_cache uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("track_buffer_write_back_cache: mismatch");
         $finish;
      end
   end

   // Notes accepted requests before checking the word taken at the same edge.
   always @(posedge clock) begin
      result_type got;
      request_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.command = req_tdata[2:0];
            seen.disk = req_tdata[4:3];
            seen.track = req_tdata[14:5];
            seen.sector = req_tdata[20:15];
            seen.disk_fault = req_tdata[21];
            board.note_request(seen);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.drive = rsp_tdata[3:0];
            got.first_block = rsp_tdata[17:4];
            got.buffer_offset = rsp_tdata[29:18];
            got.status = rsp_tdata[31:30];
            got.last = rsp_tlast;
            board.check_word(got);
         end
      end
   end

   // Result side: a random stall before each word, or a long hold-off on request.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offers one request after a random gap and waits until it is taken.
   task automatic send_request(input request_type req);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, req.disk_fault, req.sector, req.track, req.disk, req.command};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_fields(input logic [CMD_W-1:0] command, input logic [DISK_W-1:0] disk,
                              input logic [TRACK_W-1:0] track,
                              input logic [SECTOR_W-1:0] sector, input logic fault);
      request_type req;
      req.command = command;
      req.disk = disk;
      req.track = track;
      req.sector = sector;
      req.disk_fault = fault;
      send_request(req);
   endtask

   // Mostly reuses a few recent tags so hits, dirty write-backs and flushes are common.
   function automatic request_type random_request();
      request_type req;
      int pick;
      int slot;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         req.command = CMD_READ;
      end else if (pick < 65) begin
         req.command = CMD_WRITE;
      end else if (pick < 77) begin
         req.command = CMD_WRITE_SYNC;
      end else if (pick < 88) begin
         req.command = CMD_FLUSH;
      end else if (pick < 96) begin
         req.command = CMD_INVALIDATE;
      end else begin
         req.command = CMD_FIRST_UNDEFINED + CMD_W'($urandom_range(0, 2));
      end
      slot = $urandom_range(0, TAG_POOL - 1);
      if ($urandom_range(0, 3) == 0) begin
         pool_disk[slot] = DISK_W'($urandom_range(0, 3));
         pool_track[slot] = TRACK_W'($urandom_range(0, 1023));
      end
      req.disk = pool_disk[slot];
      req.track = pool_track[slot];
      if ($urandom_range(0, 9) != 0) begin
         req.sector = SECTOR_W'($urandom_range(1, SECTORS_PER_TRACK));
      end else begin
         // Sector zero or one past the end of the track and beyond.
         pick = $urandom_range(0, 31);
         req.sector = (pick == 0) ? '0 : SECTOR_W'(SECTORS_PER_TRACK + pick);
      end
      req.disk_fault = ($urandom_range(0, 3) == 0);
      return req;
   endfunction

   initial begin
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: misses, hits, range errors, write-backs and faults.
      send_fields(CMD_READ, 2'd0, 10'd0, 6'd1, 1'b0);
      send_fields(CMD_READ, 2'd0, 10'd0, 6'd32, 1'b0);
      send_fields(CMD_READ, 2'd0, 10'd0, 6'd0, 1'b0);
      send_fields(CMD_WRITE, 2'd0, 10'd0, 6'd33, 1'b1);
      send_fields(CMD_READ, 2'd1, 10'd7, 6'd63, 1'b0);
      send_fields(CMD_WRITE, 2'd3, 10'd1023, 6'd32, 1'b1);
      send_fields(CMD_WRITE, 2'd3, 10'd1023, 6'd1, 1'b0);
      send_fields(CMD_READ, 2'd2, 10'd512, 6'd16, 1'b0);
      send_fields(CMD_WRITE_SYNC, 2'd2, 10'd512, 6'd5, 1'b1);
      send_fields(CMD_FLUSH, 2'd2, 10'd512, 6'd5, 1'b0);
      send_fields(CMD_WRITE, 2'd1, 10'd341, 6'd21, 1'b0);
      send_fields(CMD_FLUSH, 2'd0, 10'd0, 6'd0, 1'b1);
      send_fields(CMD_WRITE, 2'd1, 10'd341, 6'd2, 1'b0);
      send_fields(CMD_INVALIDATE, 2'd1, 10'd341, 6'd2, 1'b0);
      send_fields(CMD_READ, 2'd1, 10'd341, 6'd3, 1'b0);
      send_fields(CMD_WRITE, 2'd0, 10'd682, 6'd10, 1'b0);
      send_fields(CMD_WRITE_SYNC, 2'd3, 10'd5, 6'd7, 1'b0);
      send_fields(CMD_WRITE_SYNC, 2'd3, 10'd5, 6'd0, 1'b1);
      send_fields(CMD_FIRST_UNDEFINED, 2'd3, 10'd1023, 6'd63, 1'b1);
      send_fields(CMD_FIRST_UNDEFINED + 3'd1, 2'd2, 10'd341, 6'd1, 1'b0);
      send_fields(CMD_FIRST_UNDEFINED + 3'd2, 2'd1, 10'd682, 6'd32, 1'b1);
      send_fields(CMD_INVALIDATE, 2'd0, 10'd0, 6'd0, 1'b1);

      // Random part, with a long result hold-off at the start and halfway.
      for (i = 0; i < TAG_POOL; i++) begin
         pool_disk[i] = DISK_W'($urandom_range(0, 3));
         pool_track[i] = TRACK_W'($urandom_range(0, 1023));
      end
      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 40 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if (i == 0 || i == RANDOM_REQUESTS / 2) begin
            hold_request = 1'b1;
         end
         send_request(random_request());
      end
      req_tvalid <= 1'b0;

      // Drain, then keep watching for any stray word before the summary.
      @(posedge clock);
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d result words: %0d fills, %0d write-backs,",
               board.requests, board.words_checked, board.fills, board.write_backs);
      $display("%0d out-of-range sectors, and two long result hold-offs.",
               board.range_errors);
      if (board.errors == 0) begin
         $display("track_buffer_write_back_cache: match");
      end else begin
         $display("track_buffer_write_back_cache: mismatch");
      end
      $finish;
   end

endmodule
